// ===== rtl/cxfe_pkg.sv =====
// ----------------------------------------------------------------------------
// cxfe_pkg: shared constants for the Chimp XOR float encoder
// Code flags, header lengths and the rounded leading-zero table.
// ----------------------------------------------------------------------------
package cxfe_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned HDR_W     = 11;
  localparam int unsigned HLEN_W    = 4;
  localparam int unsigned PLEN_W    = 7;
  localparam int unsigned LIDX_W    = 3;
  localparam int unsigned CENTER_W  = 6;

  // Two-bit code flags
  localparam logic [1:0] CODE_ZERO   = 2'b00;
  localparam logic [1:0] CODE_CENTER = 2'b01;
  localparam logic [1:0] CODE_REUSE  = 2'b10;
  localparam logic [1:0] CODE_NEW    = 2'b11;

  // Header bit counts
  localparam logic [HLEN_W-1:0] HLEN_NONE   = 4'd0;
  localparam logic [HLEN_W-1:0] HLEN_FLAG   = 4'd2;
  localparam logic [HLEN_W-1:0] HLEN_LEAD   = 4'd5;
  localparam logic [HLEN_W-1:0] HLEN_CENTER = 4'd11;

  // Trailing zeros above this count select the center form
  localparam logic [PLEN_W-1:0] TRAIL_LIMIT = 7'd6;

  // Word widths per mode
  localparam logic [PLEN_W-1:0] WIDTH_SINGLE = 7'd32;
  localparam logic [PLEN_W-1:0] WIDTH_DOUBLE = 7'd64;

  localparam logic MODE_DOUBLE = 1'b1;

  localparam logic [4:0] LEAD_TABLE [8] = '{5'd0, 5'd8, 5'd12, 5'd16,
                                            5'd18, 5'd20, 5'd22, 5'd24};

  // Largest index whose table entry does not exceed the leading-zero count
  function automatic logic [LIDX_W-1:0] lead_index(input logic [PLEN_W-1:0] lead);
    logic [LIDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) begin
      if ({2'b00, LEAD_TABLE[i]} <= lead) begin
        idx = LIDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/chimp_xor_float_encoder.sv =====
// ----------------------------------------------------------------------------
// chimp_xor_float_encoder: Chimp code word generator for float streams
// XORs each word with its predecessor and emits header and payload fields.
// ----------------------------------------------------------------------------
//
//  chan  | dir    | handshake     | fields
//  ------+--------+---------------+-----------------------------------------------
//  in    | sink   | valid, stall  | value, first_of_block, last_of_block
//  out   | source | valid, stall  | header_code, header_length, payload, ...
//  cfg   | sink   | we, no stall  | data = value_width_mode
//
// One transfer per cycle each way while no stall holds it; a result passes the
// input register, then the result register, before it shows on the out ports.
// The cycle is set by one encode pass: zero-run search, center subtract and
// payload shift; previous word and lead index advance as an item moves on.
// Reset clears the valid bits and the state and selects 64-bit mode.
// out_stall holds the result register; in_stall rises only while both are full.
// ----------------------------------------------------------------------------
module chimp_xor_float_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic                              cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cxfe_pkg::WORD_W-1:0]       in_value,
  input  logic                              in_first_of_block,
  input  logic                              in_last_of_block,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cxfe_pkg::HDR_W-1:0]        out_header_code,
  output logic [cxfe_pkg::HLEN_W-1:0]       out_header_length,
  output logic [cxfe_pkg::WORD_W-1:0]       out_payload,
  output logic [cxfe_pkg::PLEN_W-1:0]       out_payload_length,
  output logic                              out_last_out
);

  localparam int unsigned WW = cxfe_pkg::WORD_W;
  localparam int unsigned PW = cxfe_pkg::PLEN_W;
  localparam int unsigned LW = cxfe_pkg::LIDX_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic                          mode_r;
  logic                          s1_valid_r;
  logic [WW-1:0]                 s1_value_r;
  logic                          s1_first_r;
  logic                          s1_last_r;
  logic [WW-1:0]                 prev_word_r, prev_word_nxt;
  logic [LW-1:0]                 prev_lead_r, prev_lead_nxt;
  logic                          out_valid_r;
  logic [cxfe_pkg::HDR_W-1:0]    hdr_r, hdr_nxt;
  logic [cxfe_pkg::HLEN_W-1:0]   hlen_r, hlen_nxt;
  logic [WW-1:0]                 pay_r, pay_nxt;
  logic [PW-1:0]                 plen_r, plen_nxt;
  logic                          last_r;

  // --------------------------------------------------------------------------
  // Handshake: the output register frees when empty or when its transfer
  // completes; the input register drains into it whenever it frees.
  // --------------------------------------------------------------------------
  logic out_free;
  logic s1_move;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Encode stage
  // --------------------------------------------------------------------------
  logic [WW-1:0] word;
  logic [WW-1:0] prev_masked;
  logic [WW-1:0] xr;
  logic [PW-1:0] width;
  logic [PW-1:0] trail;
  logic [PW-1:0] lead64;
  logic [PW-1:0] lead;
  logic [LW-1:0] idx;
  logic [PW-1:0] lead_floor;
  logic [PW-1:0] center;

  always_comb begin
    // mask both words to the active width
    if (mode_r == cxfe_pkg::MODE_DOUBLE) begin
      word        = s1_value_r;
      prev_masked = prev_word_r;
      width       = cxfe_pkg::WIDTH_DOUBLE;
    end else begin
      word        = {{(WW/2){1'b0}}, s1_value_r[WW/2-1:0]};
      prev_masked = {{(WW/2){1'b0}}, prev_word_r[WW/2-1:0]};
      width       = cxfe_pkg::WIDTH_SINGLE;
    end
    xr = word ^ prev_masked;
  end

  // trailing zeros: lowest set bit wins
  always_comb begin
    trail = PW'(WW);
    for (int i = WW - 1; i >= 0; i--) begin
      if (xr[i]) begin
        trail = PW'(i);
      end
    end
  end

  // leading zeros over 64 bits: highest set bit wins
  always_comb begin
    lead64 = PW'(WW);
    for (int i = 0; i < WW; i++) begin
      if (xr[i]) begin
        lead64 = PW'(WW - 1 - i);
      end
    end
  end

  always_comb begin
    // in single mode the upper half is zero, so drop its 32 counts
    if (mode_r == cxfe_pkg::MODE_DOUBLE) begin
      lead = lead64;
    end else begin
      lead = lead64 - cxfe_pkg::WIDTH_SINGLE;
    end
    idx        = cxfe_pkg::lead_index(lead);
    lead_floor = {2'b00, cxfe_pkg::LEAD_TABLE[idx]};
    center     = width - lead_floor - trail;
  end

  always_comb begin
    hdr_nxt       = '0;
    hlen_nxt      = cxfe_pkg::HLEN_NONE;
    pay_nxt       = '0;
    plen_nxt      = '0;
    prev_word_nxt = word;
    prev_lead_nxt = prev_lead_r;
    if (s1_first_r) begin
      // pass the first word of a block through whole
      pay_nxt       = word;
      plen_nxt      = width;
      prev_lead_nxt = '0;
    end else if (xr == '0) begin
      hdr_nxt  = {{(cxfe_pkg::HDR_W-2){1'b0}}, cxfe_pkg::CODE_ZERO};
      hlen_nxt = cxfe_pkg::HLEN_FLAG;
    end else begin
      prev_lead_nxt = idx;
      if (trail > cxfe_pkg::TRAIL_LIMIT) begin
        // center form: flag, lead index, center length, then center bits
        hdr_nxt  = {cxfe_pkg::CODE_CENTER, idx, center[cxfe_pkg::CENTER_W-1:0]};
        hlen_nxt = cxfe_pkg::HLEN_CENTER;
        pay_nxt  = xr >> trail[5:0];
        plen_nxt = center;
      end else begin
        if (idx == prev_lead_r) begin
          hdr_nxt  = {{(cxfe_pkg::HDR_W-2){1'b0}}, cxfe_pkg::CODE_REUSE};
          hlen_nxt = cxfe_pkg::HLEN_FLAG;
        end else begin
          hdr_nxt  = {{(cxfe_pkg::HDR_W-2-LW){1'b0}}, cxfe_pkg::CODE_NEW, idx};
          hlen_nxt = cxfe_pkg::HLEN_LEAD;
        end
        pay_nxt  = xr;
        plen_nxt = width - lead_floor;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequential logic
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cxfe_pkg::MODE_DOUBLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_word_r <= '0;
      prev_lead_r <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      // input register: load on transfer, drop when drained and nothing new
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      // output register: advance when free
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      // state advances as the item is encoded
      if (s1_move) begin
        prev_word_r <= prev_word_nxt;
        prev_lead_r <= prev_lead_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_value_r <= in_value;
      s1_first_r <= in_first_of_block;
      s1_last_r  <= in_last_of_block;
    end
    if (s1_move) begin
      hdr_r  <= hdr_nxt;
      hlen_r <= hlen_nxt;
      pay_r  <= pay_nxt;
      plen_r <= plen_nxt;
      last_r <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_header_code    = hdr_r;
  assign out_header_length  = hlen_r;
  assign out_payload        = pay_r;
  assign out_payload_length = plen_r;
  assign out_last_out       = last_r;

endmodule

// ===== rtl/cxfe_checker.sv =====
// ----------------------------------------------------------------------------
// cxfe_checker: port-level checks for the Chimp XOR float encoder
// Watches the result channel for held transfers and consistent code words.
// ----------------------------------------------------------------------------
module cxfe_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [cxfe_pkg::HDR_W-1:0]        out_header_code,
  input logic [cxfe_pkg::HLEN_W-1:0]       out_header_length,
  input logic [cxfe_pkg::WORD_W-1:0]       out_payload,
  input logic [cxfe_pkg::PLEN_W-1:0]       out_payload_length,
  input logic                              out_last_out
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_header_code) &&
      $stable(out_header_length) && $stable(out_payload) &&
      $stable(out_payload_length) && $stable(out_last_out))
    else $error("stalled result changed");

  a_hlen_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_header_length == cxfe_pkg::HLEN_NONE ||
      out_header_length == cxfe_pkg::HLEN_FLAG ||
      out_header_length == cxfe_pkg::HLEN_LEAD ||
      out_header_length == cxfe_pkg::HLEN_CENTER)
    else $error("illegal header length");

  a_raw_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_length == cxfe_pkg::HLEN_NONE |->
      out_payload_length == cxfe_pkg::WIDTH_SINGLE ||
      out_payload_length == cxfe_pkg::WIDTH_DOUBLE)
    else $error("raw word with wrong length");

  a_zero_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_length == cxfe_pkg::HLEN_FLAG &&
      out_header_code[1:0] == cxfe_pkg::CODE_ZERO |->
      out_payload_length == '0 && out_payload == '0)
    else $error("zero code carries payload");

  a_center_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_length == cxfe_pkg::HLEN_CENTER |->
      out_payload_length == {1'b0, out_header_code[cxfe_pkg::CENTER_W-1:0]})
    else $error("center length mismatch");

endmodule

bind chimp_xor_float_encoder cxfe_checker u_cxfe_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_header_code    (out_header_code),
  .out_header_length  (out_header_length),
  .out_payload        (out_payload),
  .out_payload_length (out_payload_length),
  .out_last_out       (out_last_out)
);

// ===== verif/tb_chimp_xor_float_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_chimp_xor_float_encoder: self-checking bench for the Chimp XOR encoder
// Streams float words through the encoder in 64-bit and 32-bit mode and checks
// every code word against a predictor built into the bench, with random gaps
// on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_chimp_xor_float_encoder;
  import cxfe_pkg::*;

  // One input transfer as queued by the stimulus process
  typedef struct {
    logic [WORD_W-1:0] value;
    logic              first;
    logic              last;
    int unsigned       gap;    // idle cycles after this item is taken
    bit                drain;  // hold this item until all results are back
  } float_item_t;

  // One result transfer, laid out in port order
  typedef struct packed {
    logic [HDR_W-1:0]  hdr;
    logic [HLEN_W-1:0] hlen;
    logic [WORD_W-1:0] payload;
    logic [PLEN_W-1:0] plen;
    logic              last;
  } code_word_t;

  // Rounded leading-zero steps of the Chimp scheme
  localparam int unsigned LEAD_STEPS [8] = '{0, 8, 12, 16, 18, 20, 22, 24};
  localparam int unsigned MAX_STALL = 11;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic                 cfg_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [WORD_W-1:0]    in_value = '0;
  logic                 in_first_of_block = 1'b0;
  logic                 in_last_of_block = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [HDR_W-1:0]     out_header_code;
  logic [HLEN_W-1:0]    out_header_length;
  logic [WORD_W-1:0]    out_payload;
  logic [PLEN_W-1:0]    out_payload_length;
  logic                 out_last_out;

  chimp_xor_float_encoder DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_first_of_block  (in_first_of_block),
    .in_last_of_block   (in_last_of_block),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_header_code    (out_header_code),
    .out_header_length  (out_header_length),
    .out_payload        (out_payload),
    .out_payload_length (out_payload_length),
    .out_last_out       (out_last_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus side bookkeeping
  float_item_t       pending_floats[$];
  logic              gen_mode = MODE_DOUBLE;   // mode the generator assumes
  logic [WORD_W-1:0] gen_prev = '0;            // last word as the encoder stores it
  bit                tx_calm = 1'b0;           // no input gaps while set
  bit                drain_next = 1'b0;

  // Predictor state, updated at the clock edge of each transfer
  logic              width_mode;
  logic [WORD_W-1:0] prev_word;
  logic [2:0]        pred_lead_idx;
  code_word_t        code_words_due[$];

  // Transfer counters; nonblocking so other processes read settled values
  int unsigned floats_sent;
  int unsigned words_checked;
  int unsigned mismatches = 0;

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Predict the code word for one accepted float and advance the predictor
  function automatic code_word_t encode_float(input logic [WORD_W-1:0] value,
                                              input logic first, input logic last);
    code_word_t        cw;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] x;
    logic [2:0]        idx;
    logic [PLEN_W-1:0] center;
    int unsigned       nbits;
    int unsigned       trail;
    int unsigned       lead;
    int unsigned       lead_floor;
    nbits = (width_mode == MODE_DOUBLE) ? 64 : 32;
    mask  = (width_mode == MODE_DOUBLE) ? '1 : 64'hFFFF_FFFF;
    word  = value & mask;
    cw = '0;
    cw.last = last;
    if (first) begin
      // pass the raw word through and restart the lead index
      cw.payload = word;
      cw.plen = PLEN_W'(nbits);
      pred_lead_idx = '0;
    end else begin
      // the stored word is cut to the current width as well
      x = (word ^ prev_word) & mask;
      if (x == '0) begin
        cw.hdr  = HDR_W'(CODE_ZERO);
        cw.hlen = HLEN_FLAG;
      end else begin
        trail = 0;
        while (trail < nbits && !x[trail]) trail++;
        lead = 0;
        while (lead < nbits && !x[nbits-1-lead]) lead++;
        idx = '0;
        for (int i = 0; i < 8; i++) begin
          if (LEAD_STEPS[i] <= lead) idx = 3'(i);
        end
        lead_floor = LEAD_STEPS[idx];
        if (trail > TRAIL_LIMIT) begin
          // center form: only the bits between the zero runs travel
          center = PLEN_W'(nbits - lead_floor - trail);
          cw.hdr = {CODE_CENTER, idx, center[CENTER_W-1:0]};
          cw.hlen = HLEN_CENTER;
          cw.payload = x >> trail;
          cw.plen = center;
        end else begin
          if (idx == pred_lead_idx) begin
            cw.hdr  = HDR_W'(CODE_REUSE);
            cw.hlen = HLEN_FLAG;
          end else begin
            cw.hdr  = HDR_W'({CODE_NEW, idx});
            cw.hlen = HLEN_LEAD;
          end
          cw.payload = x;
          cw.plen = PLEN_W'(nbits - lead_floor);
        end
        pred_lead_idx = idx;
      end
    end
    prev_word = word;
    return cw;
  endfunction

  // Driver: present queued floats, honor gaps, hold while stalled
  int unsigned gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid          <= 1'b0;
      in_value          <= '0;
      in_first_of_block <= 1'b0;
      in_last_of_block  <= 1'b0;
      gap_left          <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left != 0) begin
        // idle between transfers
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_floats.size() != 0 &&
                   !(pending_floats[0].drain &&
                     (in_valid || floats_sent != words_checked))) begin
        in_valid          <= 1'b1;
        in_value          <= pending_floats[0].value;
        in_first_of_block <= pending_floats[0].first;
        in_last_of_block  <= pending_floats[0].last;
        gap_left          <= pending_floats[0].gap;
        void'(pending_floats.pop_front());
      end else begin
        // nothing ready, or hold the next float until the pipe is empty
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: draw a stall after every transfer, with calm stretches
  int unsigned stall_left;
  int unsigned rx_count;

  always @(posedge clk) begin : rx_side
    int unsigned n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      rx_count   <= 0;
    end else if (out_valid && !out_stall) begin
      // of every three stretches of 40 results, the second runs without stalls
      n = ((rx_count / 40) % 3 == 1) ? 0 : $urandom_range(0, MAX_STALL);
      rx_count   <= rx_count + 1;
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // Monitor: track config writes, predict on input transfers, check outputs
  always @(posedge clk) begin : monitor
    code_word_t got;
    code_word_t want;
    if (!rst_n) begin
      width_mode    = MODE_DOUBLE;
      prev_word     = '0;
      pred_lead_idx = '0;
      code_words_due.delete();
      floats_sent   <= 0;
      words_checked <= 0;
    end else begin
      if (cfg_we) width_mode = cfg_data;
      if (out_valid && !out_stall) begin
        got = {out_header_code, out_header_length, out_payload,
               out_payload_length, out_last_out};
        if (code_words_due.size() == 0) begin
          note_failure($sformatf("result with nothing due: hdr=%h hlen=%0d pay=%h plen=%0d last=%b",
                                 got.hdr, got.hlen, got.payload, got.plen, got.last));
        end else begin
          want = code_words_due.pop_front();
          words_checked <= words_checked + 1;
          if (got.hdr !== want.hdr || got.hlen !== want.hlen ||
              got.payload !== want.payload || got.plen !== want.plen ||
              got.last !== want.last) begin
            note_failure($sformatf({"code word mismatch: exp hdr=%h hlen=%0d pay=%h plen=%0d ",
                                    "last=%b, got hdr=%h hlen=%0d pay=%h plen=%0d last=%b"},
                                   want.hdr, want.hlen, want.payload, want.plen, want.last,
                                   got.hdr, got.hlen, got.payload, got.plen, got.last));
          end
        end
      end
      if (in_valid && !in_stall) begin
        code_words_due.push_back(encode_float(in_value, in_first_of_block, in_last_of_block));
        floats_sent <= floats_sent + 1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [WORD_W-1:0] gen_mask();
    return (gen_mode == MODE_DOUBLE) ? '1 : 64'hFFFF_FFFF;
  endfunction

  task automatic queue_item(input logic [WORD_W-1:0] value, input logic first,
                            input logic last);
    float_item_t it;
    it.value = value;
    it.first = first;
    it.last  = last;
    it.gap   = tx_calm ? 0 : $urandom_range(0, 11);
    it.drain = drain_next;
    drain_next = 1'b0;
    pending_floats.push_back(it);
    gen_prev = value & gen_mask();
  endtask

  // Queue the word that XORs to x against the previous one; junk the unused top
  task automatic queue_xor(input logic [WORD_W-1:0] x, input logic first,
                           input logic last);
    logic [WORD_W-1:0] m;
    m = gen_mask();
    queue_item(({$urandom, $urandom} & ~m) | ((gen_prev ^ x) & m), first, last);
  endtask

  // XOR patterns shaped like neighboring floats: short fields, varied leads
  function automatic logic [WORD_W-1:0] gen_xor();
    int unsigned w;
    int unsigned len;
    int unsigned lead;
    logic [WORD_W-1:0] x;
    w = (gen_mode == MODE_DOUBLE) ? 64 : 32;
    case ($urandom_range(0, 9))
      0: x = '0;
      1, 2, 3: begin
        len = $urandom_range(1, 20);
        x = ({$urandom, $urandom} & ((64'd1 << len) - 1)) << $urandom_range(0, w - len);
      end
      4, 5: begin
        lead = $urandom_range(0, w - 1);
        x = ({$urandom, $urandom} >> (64 - (w - lead))) | (64'd1 << (w - 1 - lead));
      end
      6: x = 64'd1 << $urandom_range(0, w - 1);
      default: x = {$urandom, $urandom};
    endcase
    return x & gen_mask();
  endfunction

  // Mostly well-formed blocks with random content, some stray flag noise
  task automatic queue_random(input int unsigned count);
    int unsigned made;
    int unsigned blen;
    made = 0;
    while (made < count) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        queue_item({$urandom, $urandom}, 1'($urandom), 1'($urandom));
        made++;
      end else begin
        blen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 16);
        drain_next = ($urandom_range(0, 7) == 0);
        queue_item({$urandom, $urandom}, 1'b1, blen == 1);
        for (int k = 1; k < blen; k++) begin
          queue_xor(gen_xor(), 1'b0, k == blen - 1);
        end
        made += blen;
      end
    end
  endtask

  // Wait until every float is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_floats.size() != 0 || in_valid || floats_sent != words_checked);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
    gen_mode = mode;
  endtask

  initial begin : stimulus
    int unsigned waited;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 64-bit directed set; start without a first item to hit reset state
    queue_xor(64'h1, 1'b0, 1'b0);
    queue_xor(64'h0, 1'b0, 1'b0);
    queue_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    queue_xor(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    drain_next = 1'b1;
    queue_xor(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    queue_xor(64'h0000_0000_0000_0080, 1'b0, 1'b0);   // seven trailing zeros
    queue_xor(64'h0100_0000_0000_0040, 1'b0, 1'b0);   // six trailing zeros
    foreach (LEAD_STEPS[i]) begin
      if (i != 0) begin
        queue_xor((64'd1 << (63 - LEAD_STEPS[i])) | 64'd1, 1'b0, 1'b0);
        queue_xor((64'd1 << (64 - LEAD_STEPS[i])) | 64'd1, 1'b0, 1'b0);
      end
    end
    queue_item(64'h0000_0000_0000_0000, 1'b1, 1'b1);
    wait_drained();

    // 32-bit directed set; the first item XORs against the word stored before the width change
    write_mode(1'b0);
    @(negedge clk);
    queue_xor(64'h0000_0000_8000_0000, 1'b0, 1'b0);
    queue_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    queue_xor(64'h0, 1'b0, 1'b0);                     // only upper junk differs
    queue_xor(64'h0000_0000_0000_00FF, 1'b0, 1'b0);
    queue_xor(64'h0000_0000_0000_0080, 1'b0, 1'b1);
    queue_random(225);
    wait_drained();

    write_mode(1'b1);
    @(negedge clk);
    queue_random(225);
    wait_drained();

    write_mode(1'b0);
    @(negedge clk);
    queue_random(225);
    wait_drained();

    write_mode(1'b1);
    @(negedge clk);
    queue_random(225);

    // drain with a bound, then let stray results show up
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((pending_floats.size() != 0 || in_valid || floats_sent != words_checked) &&
               waited < 20000);
    repeat (20) @(negedge clk);
    if (floats_sent != words_checked || pending_floats.size() != 0) begin
      note_failure($sformatf("%0d code words never arrived", floats_sent - words_checked));
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
